// ----- design/sss_pkg.sv -----
package sss_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 6;

  localparam int unsigned MAX_LENGTH_DEF = 31;

  localparam logic [LEN_W-1:0] LENGTH_RST = LEN_W'(7);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LENGTH     = 2'd0,
    REG_DESCRAMBLE = 2'd1
  } cfg_reg_e;

endpackage

// ----- design/sss_if.sv -----
interface sss_in_if;
  logic                      valid;
  logic                      ready;
  logic [sss_pkg::DATA_W-1:0] data_in;
  logic                      last_byte;

  modport source (output valid, output data_in, output last_byte, input ready);
  modport sink   (input valid, input data_in, input last_byte, output ready);
endinterface

interface sss_out_if;
  logic                      valid;
  logic                      ready;
  logic [sss_pkg::DATA_W-1:0] data_out;
  logic                      last_out;
  logic                      length_error;

  modport source (output valid, output data_out, output last_out, output length_error,
                  input ready);
  modport sink   (input valid, input data_out, input last_out, input length_error,
                  output ready);
endinterface

interface sss_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sss_pkg::CFG_IDX_W-1:0]  index;
  logic [sss_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/self_sync_scrambler.sv -----
// Byte-wide self-synchronising scrambler/descrambler with taps at delays (N+1)/2 and N of
// a MAX_LENGTH-bit delay line, bit 0 of each byte first. One byte per cycle is sustained
// while the output accepts: a byte is transferred into an input register, and all eight bit
// steps and the delay line update are done combinationally from there into the result
// register. The delay line starts at zero and clears after a byte marked last. A length that
// is even, below 3 or above MAX_LENGTH gives zero data with length_error set and leaves the
// line untouched unless the byte is marked last. Configuration writes are always accepted
// and must only be made while no byte is in flight.
module self_sync_scrambler #(
  parameter int unsigned MAX_LENGTH = sss_pkg::MAX_LENGTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  sss_cfg_if.sink  cfg_i,
  sss_in_if.sink   in_i,
  sss_out_if.source out_o
);

  localparam int unsigned TapW = $clog2(MAX_LENGTH);

  logic [sss_pkg::LEN_W-1:0]   length_q;
  logic                        descramble_q;

  logic                        s1_valid_q;
  logic [sss_pkg::DATA_W-1:0]  s1_data_q;
  logic                        s1_last_q;
  logic                        s1_adv;

  logic [MAX_LENGTH-1:0]       line_q, line_d;

  logic                        out_valid_q;
  logic [sss_pkg::DATA_W-1:0]  out_data_q, out_data_d;
  logic                        out_last_q;
  logic                        out_err_q, out_err_d;

  logic                        len_ok;
  logic [TapW-1:0]             tap_x, tap_n;
  logic [MAX_LENGTH-1:0]       work;
  logic                        fb, bit_o;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q     <= sss_pkg::LENGTH_RST;
      descramble_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        sss_pkg::REG_LENGTH:     length_q     <= cfg_i.data;
        sss_pkg::REG_DESCRAMBLE: descramble_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_data_q <= in_i.data_in;
      s1_last_q <= in_i.last_byte;
    end
  end

  assign len_ok = length_q[0] && (length_q >= sss_pkg::LEN_W'(3))
                  && (length_q <= sss_pkg::LEN_W'(MAX_LENGTH));
  assign tap_x  = TapW'(length_q >> 1);
  assign tap_n  = TapW'(length_q - sss_pkg::LEN_W'(1));

  always_comb begin
    work       = line_q;
    out_data_d = '0;
    fb         = 1'b0;
    bit_o      = 1'b0;
    for (int i = 0; i < sss_pkg::DATA_W; i++) begin
      fb            = work[tap_x] ^ work[tap_n];
      bit_o         = s1_data_q[i] ^ fb;
      out_data_d[i] = bit_o;
      work          = {work[MAX_LENGTH-2:0], descramble_q ? s1_data_q[i] : bit_o};
    end
    if (!len_ok) begin
      out_data_d = '0;
    end
    out_err_d = !len_ok;
    if (s1_last_q) begin
      line_d = '0;
    end else if (len_ok) begin
      line_d = work;
    end else begin
      line_d = line_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
    end else if (s1_adv) begin
      line_q <= line_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= out_data_d;
      out_last_q <= s1_last_q;
      out_err_q  <= out_err_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.data_out     = out_data_q;
  assign out_o.last_out     = out_last_q;
  assign out_o.length_error = out_err_q;

  a_err_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> out_data_q == '0)
    else $error("length error with non-zero data");

  a_last_clears_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> line_q == '0)
    else $error("delay line not cleared after last byte");

  a_err_holds_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !s1_last_q && !len_ok |=> $stable(line_q))
    else $error("delay line moved on length error");

  a_no_result_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q)
    else $error("result dropped while stalled");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int unsigned LINE_W      = sss_pkg::MAX_LENGTH_DEF;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned N_RUNS      = 12;
  localparam int unsigned REPORT_MAX  = 10;

  localparam logic [sss_pkg::LEN_W-1:0] RUN_LEN [N_RUNS] = '{
    6'd3, 6'd31, 6'd7, 6'd5, 6'd63, 6'd17, 6'd4, 6'd9, 6'd31, 6'd33, 6'd3, 6'd21
  };

  typedef struct packed {
    logic [sss_pkg::DATA_W-1:0] data;
    logic                       last;
  } byte_t;

  typedef struct packed {
    logic [sss_pkg::DATA_W-1:0] data;
    logic                       last;
    logic                       err;
  } scr_res_t;

  logic clk_i;
  logic rst_ni;

  sss_cfg_if cfg_bus ();
  sss_in_if  byte_in ();
  sss_out_if byte_out ();

  self_sync_scrambler u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (byte_in),
    .out_o  (byte_out)
  );

  logic [sss_pkg::LEN_W-1:0] len_q   = sss_pkg::LENGTH_RST;
  logic                      descr_q = 1'b0;
  logic [LINE_W-1:0]         line_q  = '0;

  byte_t       pending_q[$];
  scr_res_t    expected_q[$];
  byte_t       next_byte;
  scr_res_t    want;
  int unsigned src_gap_pct;
  int unsigned snk_gap_pct;
  logic        hold_req;
  logic        hold_taken;
  int unsigned hold_left;
  int unsigned quiet;
  int unsigned n_bytes = 0;
  int unsigned n_msgs  = 0;
  int unsigned n_err   = 0;
  int unsigned n_cfg   = 0;
  int unsigned n_mism  = 0;

  function automatic scr_res_t scramble_step(byte_t b);
    scr_res_t    r;
    int unsigned tap_mid;
    int unsigned tap_end;
    logic        o;
    r = '{data: '0, last: b.last, err: 1'b0};
    if (len_q[0] && len_q >= 3 && len_q <= LINE_W) begin
      tap_mid = (len_q + 1) / 2 - 1;
      tap_end = len_q - 1;
      for (int i = 0; i < sss_pkg::DATA_W; i++) begin
        o = b.data[i] ^ line_q[tap_mid] ^ line_q[tap_end];
        line_q = {line_q[LINE_W-2:0], descr_q ? b.data[i] : o};
        r.data[i] = o;
      end
    end else begin
      r.err = 1'b1;
    end
    if (b.last) begin
      line_q = '0;
    end
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // byte source
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_in.valid <= 1'b0;
    end else if (!byte_in.valid || byte_in.ready) begin
      if (byte_in.valid) begin
        want = scramble_step('{data: byte_in.data_in, last: byte_in.last_byte});
        expected_q.push_back(want);
        n_bytes++;
        if (byte_in.last_byte) n_msgs++;
        if (want.err) n_err++;
      end
      if (pending_q.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
        next_byte = pending_q.pop_front();
        byte_in.valid     <= 1'b1;
        byte_in.data_in   <= next_byte.data;
        byte_in.last_byte <= next_byte.last;
      end else begin
        byte_in.valid <= 1'b0;
      end
    end
  end

  // result sink, with one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_out.ready <= 1'b0;
      hold_taken     <= 1'b0;
      hold_left      <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken     <= 1'b1;
      hold_left      <= HOLD_CYCLES;
      byte_out.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      byte_out.ready <= 1'b0;
    end else begin
      byte_out.ready <= ($urandom_range(99) >= snk_gap_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_bus.valid && cfg_bus.ready) begin
      n_cfg++;
      case (sss_pkg::cfg_reg_e'(cfg_bus.index))
        sss_pkg::REG_LENGTH:     len_q   <= cfg_bus.data[sss_pkg::LEN_W-1:0];
        sss_pkg::REG_DESCRAMBLE: descr_q <= cfg_bus.data[0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && byte_out.valid && byte_out.ready) begin
      if (expected_q.size() == 0) begin
        n_mism++;
        if (n_mism <= REPORT_MAX) begin
          $display("%0t: result with nothing outstanding: data %h last %b err %b", $time,
                   byte_out.data_out, byte_out.last_out, byte_out.length_error);
        end
      end else begin
        want = expected_q.pop_front();
        if (byte_out.data_out !== want.data || byte_out.last_out !== want.last ||
            byte_out.length_error !== want.err) begin
          n_mism++;
          if (n_mism <= REPORT_MAX) begin
            $display("%0t: got data %h last %b err %b, expected data %h last %b err %b",
                     $time, byte_out.data_out, byte_out.last_out, byte_out.length_error,
                     want.data, want.last, want.err);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (byte_in.valid && byte_in.ready) || (byte_out.valid && byte_out.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_byte(input logic [sss_pkg::DATA_W-1:0] d, input logic l);
    pending_q.push_back('{data: d, last: l});
  endtask

  // mostly whole messages; some run on into the next without a last marker
  task automatic send_messages(input int unsigned n_items);
    int unsigned left;
    int unsigned run;
    logic [sss_pkg::DATA_W-1:0] d;
    left = n_items;
    while (left > 0) begin
      run = $urandom_range(24, 1);
      if (run > left) run = left;
      for (int unsigned k = 0; k < run; k++) begin
        d = ($urandom_range(7) == 0) ? {sss_pkg::DATA_W{1'($urandom_range(1))}}
                                     : sss_pkg::DATA_W'($urandom);
        send_byte(d, (k == run - 1) && ($urandom_range(9) != 0));
      end
      left -= run;
    end
  endtask

  task automatic settle();
    while (pending_q.size() != 0 || byte_in.valid || expected_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [sss_pkg::LEN_W-1:0] n, input logic descr);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= sss_pkg::REG_LENGTH;
    cfg_bus.data  <= sss_pkg::CFG_DATA_W'(n);
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.index <= sss_pkg::REG_DESCRAMBLE;
    cfg_bus.data  <= sss_pkg::CFG_DATA_W'(descr);
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni            = 1'b0;
    byte_in.valid     = 1'b0;
    byte_in.data_in   = '0;
    byte_in.last_byte = 1'b0;
    byte_out.ready    = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = sss_pkg::REG_LENGTH;
    cfg_bus.data      = '0;
    src_gap_pct       = 30;
    snk_gap_pct       = 58;
    hold_req          = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, extremes, then a closed message
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h33, 1'b0);
    settle();
    // bad length mid-message: line must hold
    write_regs(6'd2, 1'b0);
    send_byte(8'h5A, 1'b0);
    settle();
    write_regs(6'd3, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();
    write_regs(6'd31, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);
    settle();
    // bad length with last must still clear the line
    write_regs(6'd33, 1'b1);
    send_byte(8'h12, 1'b1);
    settle();
    write_regs(6'd1, 1'b1);
    send_byte(8'h7E, 1'b0);
    settle();
    write_regs(6'd0, 1'b0);
    send_byte(8'h81, 1'b0);
    settle();
    write_regs(6'd63, 1'b0);
    send_byte(8'hFF, 1'b0);
    settle();
    write_regs(6'd5, 1'b1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hA5, 1'b1);
    settle();
    write_regs(6'd31, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    settle();

    for (int p = 0; p < N_RUNS; p++) begin
      if (p < 4) begin
        src_gap_pct = 30;
        snk_gap_pct = 58;
      end else if (p < 8) begin
        src_gap_pct = 58;
        snk_gap_pct = 30;
      end else begin
        src_gap_pct = 0;
        snk_gap_pct = 0;
      end
      write_regs(RUN_LEN[p], 1'(p));
      if (p == 8) hold_req = 1'b1;
      if (RUN_LEN[p][0] && RUN_LEN[p] >= 3 && RUN_LEN[p] <= LINE_W) begin
        send_messages(55);
      end else begin
        send_messages(12);
      end
      settle();
    end

    $display("Ran %0d bytes in %0d closed messages, %0d register writes, %0d under a bad length.",
             n_bytes, n_msgs, n_cfg, n_err);
    $display("Both directions, a spread of lengths from 0 to 63, stalls on both sides; %0d mismatches.",
             n_mism);
    if (n_mism == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
